FILE: hdl/grs_pkg.sv
// Package for the grouped running sum block.
// Holds the table sizes, field widths, action codes and the shared control
// struct. It depends on nothing else.
package grs_pkg;

  // Table size and sum width.
  localparam int GROUPS  = 256;
  localparam int SUM_W   = 32;
  localparam int IDX_W   = (GROUPS > 1) ? $clog2(GROUPS) : 1;

  // Field widths of the request and result channels.
  localparam int ACT_W   = 2;
  localparam int FIELD_W = 32;

  // Action codes.
  localparam logic [ACT_W-1:0] ACT_ACCUMULATE = 2'd0;
  localparam logic [ACT_W-1:0] ACT_READ       = 2'd1;
  localparam logic [ACT_W-1:0] ACT_NEW_SET    = 2'd2;

  typedef logic [IDX_W-1:0]        idx_t;
  typedef logic signed [SUM_W-1:0] sum_t;

  // Updates to the group seen bits.
  typedef struct packed {
    logic set;
    logic clr_all;
    idx_t idx;
  } seen_ctl_t;

  // Sign extends or truncates a sum to the width of a result field.
  function automatic logic signed [FIELD_W-1:0] sum_to_field(sum_t s);
    logic signed [FIELD_W-1:0] r;
    r = FIELD_W'(s);
    return r;
  endfunction

  // Sign extends or truncates a request value to the sum width.
  function automatic sum_t field_to_sum(logic signed [FIELD_W-1:0] v);
    sum_t r;
    r = SUM_W'(v);
    return r;
  endfunction

endpackage

FILE: hdl/grouped_running_sum_top.sv
// Top level of the grouped running sum block.
// Uses grs_pkg, grs_sum_ram and grs_seen_bits.
// A request goes through the read stage registers, then the result registers.
// Throughput: one request per cycle without out_stall, set by the single RAM port
// pair; back-to-back requests to one group take a forwarded sum, not RAM data.
// Reset clears the pipeline valids and all seen bits; the sum RAM is not cleared.
module grouped_running_sum_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [grs_pkg::ACT_W-1:0]           in_action,
  input  logic signed [grs_pkg::FIELD_W-1:0]  in_group_id,
  input  logic signed [grs_pkg::FIELD_W-1:0]  in_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [grs_pkg::FIELD_W-1:0]  out_sum_before,
  output logic signed [grs_pkg::FIELD_W-1:0]  out_sum_after,
  output logic                                out_bad_group
);
  import grs_pkg::*;

  logic in_accept;
  logic s1_adv;

  // Read stage registers.
  logic             s1_valid_r, s1_valid_nxt;
  logic [ACT_W-1:0] s1_act_r;
  idx_t             s1_idx_r;
  logic             s1_bad_r;
  sum_t             s1_val_r;
  logic             fwd_valid_r, fwd_valid_nxt;
  sum_t             fwd_data_r;

  // Result registers.
  logic                      out_valid_r, out_valid_nxt;
  logic signed [FIELD_W-1:0] out_before_r;
  logic signed [FIELD_W-1:0] out_after_r;
  logic                      out_bad_r;

  logic      in_bad;
  idx_t      in_idx;
  sum_t      rd_data;
  logic      rd_seen;
  sum_t      cur_sum;
  sum_t      new_sum;
  logic      s1_is_acc;
  logic      s1_is_rd;
  logic      wr_en;
  seen_ctl_t seen_ctl;

  // Handshake: the read stage moves on when the result register is free.
  assign s1_adv    = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !s1_adv;
  assign in_accept = in_valid && !in_stall;

  // Decode the group id of an incoming request.
  assign in_bad = ($unsigned(in_group_id) >= FIELD_W'(GROUPS));
  assign in_idx = in_group_id[IDX_W-1:0];

  // Sum memory, read at acceptance and written when an accumulate retires.
  grs_sum_ram #(
    .DEPTH  (GROUPS),
    .WIDTH  (SUM_W),
    .ADDR_W (IDX_W)
  ) u_sum_ram (
    .clk     (clk),
    .rd_en   (in_accept),
    .rd_addr (in_idx),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (s1_idx_r),
    .wr_data (new_sum)
  );

  grs_seen_bits u_seen (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (seen_ctl),
    .rd_idx  (s1_idx_r),
    .rd_seen (rd_seen)
  );

  // Read-modify-write in the read stage, with forwarding of the last write.
  always_comb begin
    s1_is_acc = (s1_act_r == ACT_ACCUMULATE) && !s1_bad_r;
    s1_is_rd  = (s1_act_r == ACT_READ) && !s1_bad_r;
    if (!rd_seen) begin
      cur_sum = '0;
    end else if (fwd_valid_r) begin
      cur_sum = fwd_data_r;
    end else begin
      cur_sum = rd_data;
    end
    new_sum          = cur_sum + s1_val_r;
    wr_en            = s1_adv && s1_is_acc;
    seen_ctl.set     = wr_en;
    seen_ctl.clr_all = s1_adv && (s1_act_r == ACT_NEW_SET);
    seen_ctl.idx     = s1_idx_r;
  end

  // Next values of the control registers.
  always_comb begin
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
    fwd_valid_nxt = fwd_valid_r;
    if (in_accept) begin
      fwd_valid_nxt = wr_en && (in_idx == s1_idx_r);
    end else if (s1_adv) begin
      fwd_valid_nxt = 1'b0;
    end
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      fwd_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      fwd_valid_r <= fwd_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Request payload into the read stage.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_act_r   <= in_action;
      s1_idx_r   <= in_idx;
      s1_bad_r   <= in_bad;
      s1_val_r   <= field_to_sum(in_value);
      fwd_data_r <= new_sum;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      if (s1_is_acc) begin
        out_before_r <= sum_to_field(cur_sum);
        out_after_r  <= sum_to_field(new_sum);
      end else if (s1_is_rd) begin
        out_before_r <= sum_to_field(cur_sum);
        out_after_r  <= sum_to_field(cur_sum);
      end else begin
        out_before_r <= '0;
        out_after_r  <= '0;
      end
      out_bad_r <= s1_bad_r &&
                   ((s1_act_r == ACT_ACCUMULATE) || (s1_act_r == ACT_READ));
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sum_before = out_before_r;
  assign out_sum_after  = out_after_r;
  assign out_bad_group  = out_bad_r;

`ifndef SYNTH
  // A stalled request means the read stage is occupied.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r))
    else $error("request stalled with an empty read stage");

  // Forwarding only applies to a live item in the read stage.
  a_fwd_live: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_valid_r |-> s1_valid_r)
    else $error("forward flag without an item in the read stage");

  // A bad group reports zero sums.
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_bad_r) |-> (out_before_r == '0 && out_after_r == '0))
    else $error("bad group result carries a sum");
`endif

endmodule

FILE: hdl/grs_sum_ram.sv
// Generic simple dual port synchronous RAM with a registered read.
// Holds the per group sums; it uses no package.
module grs_sum_ram #(
  parameter int DEPTH  = 256,
  parameter int WIDTH  = 32,
  parameter int ADDR_W = 8
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; the data holds while no read is requested.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hdl/grs_seen_bits.sv
// Valid bits that mark which groups hold a written sum.
// Uses grs_pkg for the index type and the control struct.
module grs_seen_bits (
  input  logic               clk,
  input  logic               rst_n,
  input  grs_pkg::seen_ctl_t ctl,
  input  grs_pkg::idx_t      rd_idx,
  output logic               rd_seen
);
  import grs_pkg::*;

  logic [GROUPS-1:0] seen_r;
  logic [GROUPS-1:0] seen_nxt;

  // A new set clears every bit at once; an accumulate marks its group.
  always_comb begin
    seen_nxt = seen_r;
    if (ctl.clr_all) begin
      seen_nxt = '0;
    end else if (ctl.set) begin
      seen_nxt[ctl.idx] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0;
    end else begin
      seen_r <= seen_nxt;
    end
  end

  assign rd_seen = seen_r[rd_idx];

`ifndef SYNTH
  // After a new set no group may still be marked.
  a_clear_all: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.clr_all |=> (seen_r == '0))
    else $error("seen bits not cleared after new set");

  // A set without a clear leaves its group marked.
  a_set_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.set && !ctl.clr_all) |=> seen_r[$past(ctl.idx)])
    else $error("seen bit not set after accumulate");
`endif

endmodule

FILE: tb/grs_checker.sv
`timescale 1ns / 1ps
// Result checker for the grouped running sum block.
// Watches the request and result channels, predicts each result from its own
// copy of the group table and compares in order. Depends on grs_pkg.
module grs_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic [grs_pkg::ACT_W-1:0]           in_action,
  input  logic signed [grs_pkg::FIELD_W-1:0]  in_group_id,
  input  logic signed [grs_pkg::FIELD_W-1:0]  in_value,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic signed [grs_pkg::FIELD_W-1:0]  out_sum_before,
  input  logic signed [grs_pkg::FIELD_W-1:0]  out_sum_after,
  input  logic                                out_bad_group,
  output int                                  mismatch_count,
  output int                                  pending
);
  import grs_pkg::*;

  typedef struct packed {
    logic signed [FIELD_W-1:0] sum_before;
    logic signed [FIELD_W-1:0] sum_after;
    logic                      bad_group;
  } group_result_t;

  // Shadow copy of the group table and its seen bits.
  sum_t          group_total [GROUPS];
  logic          group_seen [GROUPS];
  group_result_t sums_due [$];
  int            fail_total;

  assign mismatch_count = fail_total;

  // Applies one request to the shadow table and returns the result it should
  // produce. A group that was never written since the last new set reads zero.
  function automatic group_result_t update_group_sum(logic [ACT_W-1:0] action,
                                                     logic [FIELD_W-1:0] gid,
                                                     logic [FIELD_W-1:0] value);
    group_result_t r;
    sum_t          cur;
    sum_t          nxt;
    idx_t          idx;
    r   = '0;
    idx = gid[IDX_W-1:0];
    case (action)
      ACT_NEW_SET: begin
        foreach (group_seen[i]) group_seen[i] = 1'b0;
      end
      ACT_ACCUMULATE, ACT_READ: begin
        if (gid >= FIELD_W'(GROUPS)) begin
          r.bad_group = 1'b1;
        end else begin
          cur = group_seen[idx] ? group_total[idx] : '0;
          nxt = cur;
          if (action == ACT_ACCUMULATE) begin
            nxt = cur + sum_t'($signed(value));
            group_total[idx] = nxt;
            group_seen[idx]  = 1'b1;
          end
          r.sum_before = FIELD_W'(cur);
          r.sum_after  = FIELD_W'(nxt);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin : watch_channels
    group_result_t got;
    group_result_t want;
    if (!rst_n) begin
      foreach (group_seen[i]) group_seen[i] = 1'b0;
      sums_due.delete();
    end else begin
      // Results leave in request order, so each one is checked against the oldest.
      if (out_valid && !out_stall) begin
        got = {out_sum_before, out_sum_after, out_bad_group};
        if (sums_due.size() == 0) begin
          fail_total++;
          if (fail_total <= 10)
            $display("%0t: result with no request waiting: before %h after %h bad %b",
                     $time, got.sum_before, got.sum_after, got.bad_group);
        end else begin
          want = sums_due.pop_front();
          if (got !== want) begin
            fail_total++;
            if (fail_total <= 10)
              $display("%0t: expected before %h after %h bad %b, got before %h after %h bad %b",
                       $time, want.sum_before, want.sum_after, want.bad_group,
                       got.sum_before, got.sum_after, got.bad_group);
          end
        end
      end
      if (in_valid && !in_stall)
        sums_due.push_back(update_group_sum(in_action, in_group_id, in_value));
    end
    pending <= sums_due.size();
  end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// Top of the grouped running sum testbench.
// Drives requests and result stalls into grouped_running_sum_top and takes the
// verdict from grs_checker. Depends on grs_pkg.
module tb_top;
  import grs_pkg::*;

  // Action code the block must treat as a no-op.
  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

  localparam logic [FIELD_W-1:0] FIELD_MAX  = {1'b0, {(FIELD_W-1){1'b1}}};
  localparam logic [FIELD_W-1:0] FIELD_MIN  = {1'b1, {(FIELD_W-1){1'b0}}};
  localparam logic [FIELD_W-1:0] LAST_GROUP = FIELD_W'(GROUPS - 1);

  localparam int WATCHDOG_LIMIT   = 5000;
  localparam int HOLD_CYCLES      = 300;
  localparam int HOLD_AT          = 1200;
  localparam int RANDOM_PER_PHASE = 550;
  localparam int DRAIN_CYCLES     = 10;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [ACT_W-1:0]          in_action = ACT_ACCUMULATE;
  logic signed [FIELD_W-1:0] in_group_id = '0;
  logic signed [FIELD_W-1:0] in_value = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [FIELD_W-1:0] out_sum_before;
  logic signed [FIELD_W-1:0] out_sum_after;
  logic                      out_bad_group;

  int send_idle_pct = 29;
  int recv_idle_pct = 73;
  int accepted = 0;
  int quiet_cycles = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int mismatch_count;
  int pending;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  grouped_running_sum_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_action      (in_action),
    .in_group_id    (in_group_id),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_sum_before (out_sum_before),
    .out_sum_after  (out_sum_after),
    .out_bad_group  (out_bad_group)
  );

  grs_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_action      (in_action),
    .in_group_id    (in_group_id),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_sum_before (out_sum_before),
    .out_sum_after  (out_sum_after),
    .out_bad_group  (out_bad_group),
    .mismatch_count (mismatch_count),
    .pending        (pending)
  );

  // Receiver: random stalls, plus one long hold once the run is well under way.
  always @(posedge clk) begin
    if (!hold_done && accepted == HOLD_AT) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99, 0) < recv_idle_pct);
    end
  end

  // Request count and watchdog on cycles where neither channel moves.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall)
        accepted <= accepted + 1;
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Offers one request, idling first at the current rate, and waits until taken.
  task automatic send_request(input logic [ACT_W-1:0] act, input logic [FIELD_W-1:0] gid,
                              input logic [FIELD_W-1:0] val);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_action   <= act;
    in_group_id <= gid;
    in_value    <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Random request: often a few hot groups so sums build up and collide back to
  // back, some spread over the table, and a few ids outside it.
  task automatic send_random_request();
    logic [ACT_W-1:0]   act;
    logic [FIELD_W-1:0] gid;
    logic [FIELD_W-1:0] val;
    int                 pick;
    pick = $urandom_range(99, 0);
    act  = (pick < 60) ? ACT_ACCUMULATE : (pick < 97) ? ACT_READ : ACT_NEW_SET;
    pick = $urandom_range(99, 0);
    if (pick < 45)
      gid = $urandom_range(3, 0);
    else if (pick < 85)
      gid = $urandom_range(GROUPS - 1, 0);
    else if (pick < 88)
      gid = LAST_GROUP;
    else if (pick < 90)
      gid = FIELD_W'(GROUPS);
    else
      gid = $urandom();
    pick = $urandom_range(99, 0);
    if (pick < 10) begin
      case ($urandom_range(4, 0))
        0:       val = FIELD_MAX;
        1:       val = FIELD_MIN;
        2:       val = '1;
        3:       val = '0;
        default: val = FIELD_W'(1);
      endcase
    end else if (pick < 50) begin
      val = FIELD_W'($urandom_range(200, 0)) - FIELD_W'(100);
    end else begin
      val = $urandom();
    end
    send_request(act, gid, val);
  endtask

  initial begin : stimulus
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: wrap at both ends, table edges, bad ids, no-op code, new set.
    send_request(ACT_NEW_SET, $urandom(), $urandom());
    send_request(ACT_READ, '0, $urandom());
    send_request(ACT_ACCUMULATE, '0, FIELD_MAX);
    send_request(ACT_ACCUMULATE, '0, 1);
    send_request(ACT_ACCUMULATE, '0, FIELD_MIN);
    send_request(ACT_READ, '0, $urandom());
    send_request(ACT_ACCUMULATE, LAST_GROUP, '1);
    send_request(ACT_ACCUMULATE, LAST_GROUP, FIELD_MIN);
    send_request(ACT_READ, LAST_GROUP, '0);
    send_request(ACT_ACCUMULATE, FIELD_W'(GROUPS), 5);
    send_request(ACT_READ, '1, 0);
    send_request(ACT_ACCUMULATE, FIELD_MIN, FIELD_MAX);
    send_request(ACT_READ, FIELD_MAX, '1);
    send_request(ACT_UNUSED, 3, 9);
    send_request(ACT_READ, 3, 0);
    send_request(ACT_ACCUMULATE, 3, FIELD_MIN);
    send_request(ACT_ACCUMULATE, 3, FIELD_MIN);
    send_request(ACT_NEW_SET, '1, FIELD_MAX);
    // Old sums must stay hidden once a new set has started.
    send_request(ACT_READ, '0, 0);
    send_request(ACT_ACCUMULATE, '0, 7);
    send_request(ACT_READ, LAST_GROUP, 0);
    send_request(ACT_ACCUMULATE, LAST_GROUP, FIELD_MAX);

    // Random phases: sender idles lightly, then heavily, then not at all.
    repeat (RANDOM_PER_PHASE) send_random_request();
    send_idle_pct = 73;
    recv_idle_pct <= 29;
    repeat (RANDOM_PER_PHASE) send_random_request();
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    repeat (RANDOM_PER_PHASE) send_random_request();
    in_valid <= 1'b0;

    // Drain the block before the verdict.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
